/* hdl/rma_pkg.sv */
// Package for the rotation matrix accumulator.
// Holds the element type, axis codes, sequencer states, shared structs and the sine table.
// No dependencies.
`default_nettype none

package rma_pkg;

  localparam int ElemW     = 18;
  localparam int MatrixDim = 4;
  localparam int Cells     = MatrixDim * MatrixDim;

  typedef logic signed [ElemW-1:0] elem_t;

  localparam elem_t ElemMax = 18'sh1FFFF;
  localparam elem_t ElemMin = 18'sh20000;

  localparam logic [1:0] AxisX    = 2'd0;
  localparam logic [1:0] AxisY    = 2'd1;
  localparam logic [1:0] AxisZ    = 2'd2;
  localparam logic [1:0] AxisNone = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_TRIG_F,
    ST_TRIG_R,
    ST_MAC,
    ST_DRAIN,
    ST_EMIT
  } state_e;

  typedef struct packed {
    elem_t c;
    elem_t s;
    elem_t ns;
  } trig_t;

  typedef struct packed {
    logic       first;
    logic       last;
    logic [4:0] idx;
  } mac_tag_t;

  localparam logic [16:0] QuarterSine [91] = '{
    17'd0,     17'd1144,  17'd2287,  17'd3430,  17'd4572,  17'd5712,  17'd6850,
    17'd7987,  17'd9121,  17'd10252, 17'd11380, 17'd12505, 17'd13626, 17'd14742,
    17'd15855, 17'd16962, 17'd18064, 17'd19161, 17'd20252, 17'd21336, 17'd22415,
    17'd23486, 17'd24550, 17'd25607, 17'd26656, 17'd27697, 17'd28729, 17'd29753,
    17'd30767, 17'd31772, 17'd32768, 17'd33754, 17'd34729, 17'd35693, 17'd36647,
    17'd37590, 17'd38521, 17'd39441, 17'd40348, 17'd41243, 17'd42126, 17'd42995,
    17'd43852, 17'd44695, 17'd45525, 17'd46341, 17'd47143, 17'd47930, 17'd48703,
    17'd49461, 17'd50203, 17'd50931, 17'd51643, 17'd52339, 17'd53020, 17'd53684,
    17'd54332, 17'd54963, 17'd55578, 17'd56175, 17'd56756, 17'd57319, 17'd57865,
    17'd58393, 17'd58903, 17'd59396, 17'd59870, 17'd60326, 17'd60764, 17'd61183,
    17'd61584, 17'd61966, 17'd62328, 17'd62672, 17'd62997, 17'd63303, 17'd63589,
    17'd63856, 17'd64104, 17'd64332, 17'd64540, 17'd64729, 17'd64898, 17'd65048,
    17'd65177, 17'd65287, 17'd65376, 17'd65446, 17'd65496, 17'd65526, 17'd65536
  };

  function automatic logic [16:0] quarter_sine(logic [6:0] idx);
    return (idx <= 7'd90) ? QuarterSine[idx] : 17'd0;
  endfunction

endpackage

`default_nettype wire

/* hdl/rma_trig.sv */
// Sine and cosine unit: folds a reduced angle onto the quarter-wave table
// and converts the magnitudes to saturated fixed-point elements. Uses rma_pkg.
`default_nettype none

module rma_trig #(
  parameter int FRAC_BITS = 16
) (
  input  logic [8:0]     angle_i,
  output rma_pkg::trig_t trig_o
);
  import rma_pkg::*;

  localparam int Shl = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
  localparam int Shr = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
  localparam logic [31:0] Rnd = (32'd1 << Shr) >> 1;

  function automatic elem_t to_elem(logic [16:0] mag, logic neg);
    logic [31:0] wide;
    elem_t       r;
    wide = ((32'(mag) + Rnd) << Shl) >> Shr;
    if (neg) begin
      r = (wide > 32'd131072) ? ElemMin : elem_t'(18'd0 - wide[17:0]);
    end else begin
      r = (wide > 32'd131071) ? ElemMax : elem_t'(wide[17:0]);
    end
    return r;
  endfunction

  function automatic logic [6:0] fold(logic [9:0] a_in, output logic neg);
    logic [9:0] a;
    logic [9:0] idx;
    a = (a_in >= 10'd360) ? a_in - 10'd360 : a_in;
    neg = (a > 10'd180);
    if (a <= 10'd90) begin
      idx = a;
    end else if (a <= 10'd180) begin
      idx = 10'd180 - a;
    end else if (a <= 10'd270) begin
      idx = a - 10'd180;
    end else begin
      idx = 10'd360 - a;
    end
    return idx[6:0];
  endfunction

  logic [6:0]  s_idx, c_idx;
  logic        s_neg, c_neg;
  logic [16:0] s_mag, c_mag;

  always_comb begin
    s_idx = fold({1'b0, angle_i}, s_neg);
    c_idx = fold({1'b0, angle_i} + 10'd90, c_neg);
    s_mag = quarter_sine(s_idx);
    c_mag = quarter_sine(c_idx);
    trig_o.s  = to_elem(s_mag, s_neg);
    trig_o.ns = to_elem(s_mag, !s_neg);
    trig_o.c  = to_elem(c_mag, c_neg);
  end

endmodule

`default_nettype wire

/* hdl/rma_mac.sv */
// Shared multiply-accumulate unit: registered product, accumulator,
// round-to-nearest and saturation of each finished dot product. Uses rma_pkg.
`default_nettype none

module rma_mac #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               issue_i,
  input  rma_pkg::elem_t     a_i,
  input  rma_pkg::elem_t     b_i,
  input  rma_pkg::mac_tag_t  tag_i,
  output logic               busy_o,
  output logic               wr_en_o,
  output logic [4:0]         wr_idx_o,
  output rma_pkg::elem_t     wr_data_o
);
  import rma_pkg::*;

  localparam int AccW = 39;
  localparam logic signed [AccW-1:0] Bias = AccW'(1) << (FRAC_BITS - 1);

  logic signed [35:0]     prod_q;
  logic                   prod_vld_q;
  mac_tag_t               prod_tag_q;
  logic signed [AccW-1:0] acc_q, acc_d;
  logic                   done_q;
  logic [4:0]             done_idx_q;
  logic signed [AccW-1:0] rounded;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      prod_vld_q <= issue_i;
      done_q     <= prod_vld_q && prod_tag_q.last;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q     <= a_i * b_i;
    prod_tag_q <= tag_i;
    if (prod_vld_q) begin
      acc_q <= acc_d;
    end
    done_idx_q <= prod_tag_q.idx;
  end

  always_comb begin
    acc_d   = (prod_tag_q.first ? '0 : acc_q) + AccW'(prod_q);
    rounded = (acc_q + Bias) >>> FRAC_BITS;
    if (rounded > AccW'(131071)) begin
      wr_data_o = ElemMax;
    end else if (rounded < -AccW'(131072)) begin
      wr_data_o = ElemMin;
    end else begin
      wr_data_o = elem_t'(rounded[17:0]);
    end
  end

  assign wr_en_o  = done_q;
  assign wr_idx_o = done_idx_q;
  assign busy_o   = prod_vld_q || done_q;

endmodule

`default_nettype wire

/* hdl/rotation_matrix_accumulator_unit.sv */
// Top level of the rotation matrix accumulator: sequencer, matrix store and output register.
// Uses rma_pkg, rma_trig and rma_mac.
//
// One command runs through angle reduction (a reciprocal multiply for the quotient by 360, then
// one subtract), a table step for each of the forward and reverse angles, the multiply-accumulate
// loop (both 4x4 products through the single 18x18 multiplier, one product a cycle), pipeline
// drain, transfer of all 32 result elements and a return to idle, in which the next command is
// taken. A command with axis code 3 is accepted and dropped and gives no results. The input is
// not ready while a command is in progress; the last result may still wait while the next
// command is taken.
`default_nettype none

module rotation_matrix_accumulator_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          command_i,
  input  logic signed [15:0]  angle_degrees_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                matrix_select_o,
  output logic [1:0]          row_o,
  output logic [1:0]          col_o,
  output rma_pkg::elem_t      element_value_o,
  output logic                last_o
);
  import rma_pkg::*;

  localparam elem_t OneElem = (FRAC_BITS >= 17) ? ElemMax : elem_t'(1 << FRAC_BITS);
  localparam logic [14:0] RecipMul = 15'd23302;

  function automatic elem_t rot_elem(logic [1:0] axis, logic [1:0] k, logic [1:0] j,
                                     trig_t t);
    logic [1:0] p, q;
    elem_t      r;
    case (axis)
      AxisX: begin
        p = 2'd1;
        q = 2'd2;
      end
      AxisY: begin
        p = 2'd2;
        q = 2'd0;
      end
      default: begin
        p = 2'd0;
        q = 2'd1;
      end
    endcase
    r = (k == j) ? OneElem : '0;
    if (k == p && j == p) begin
      r = t.c;
    end else if (k == p && j == q) begin
      r = t.ns;
    end else if (k == q && j == p) begin
      r = t.s;
    end else if (k == q && j == q) begin
      r = t.c;
    end
    return r;
  endfunction

  state_e      state_q, state_d;
  logic [1:0]  axis_q;
  logic        neg_q;
  logic [16:0] red_q;
  logic [6:0]  quo_q;
  logic        sh_q;
  logic [8:0]  rev_q;
  logic [6:0]  iss_q;
  logic [4:0]  em_q;
  trig_t       trig_f_q, trig_r_q;
  elem_t       mem_q [Cells*2];
  elem_t       row_q [MatrixDim];

  logic        out_vld_q;
  logic        out_sel_q, out_last_q;
  logic [1:0]  out_row_q, out_col_q;
  elem_t       out_val_q;

  logic [31:0] quo_prod;
  logic [8:0]  fwd_ang, rev_ang, trig_ang;
  trig_t       trig_w;
  logic        accept, issue, load_out;
  logic [4:0]  rd_addr;
  elem_t       rd_data, mac_a, mac_b;
  mac_tag_t    tag;
  logic        mac_busy, wr_en;
  logic [4:0]  wr_idx;
  elem_t       wr_data;

  logic        mat_sel;
  logic [1:0]  iss_i, iss_j, iss_k;

  assign mat_sel = iss_q[6];
  assign iss_i   = iss_q[5:4];
  assign iss_j   = iss_q[3:2];
  assign iss_k   = iss_q[1:0];

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign issue      = (state_q == ST_MAC);
  assign load_out   = (state_q == ST_EMIT) && (!out_vld_q || out_ready_i);

  assign quo_prod = 32'(red_q) * 32'(RecipMul);
  assign fwd_ang  = (neg_q && red_q[8:0] != 9'd0) ? 9'd360 - red_q[8:0] : red_q[8:0];
  assign rev_ang  = (fwd_ang == 9'd0) ? 9'd0 : 9'd360 - fwd_ang;
  assign trig_ang = (state_q == ST_TRIG_R) ? rev_q : fwd_ang;

  rma_trig #(
    .FRAC_BITS(FRAC_BITS)
  ) u_trig (
    .angle_i(trig_ang),
    .trig_o (trig_w)
  );

  assign rd_addr = (state_q == ST_EMIT) ? em_q : {mat_sel, iss_i, iss_k};
  assign rd_data = mem_q[rd_addr];
  assign mac_a   = (iss_j == 2'd0) ? rd_data : row_q[iss_k];
  assign mac_b   = rot_elem(axis_q, iss_k, iss_j, mat_sel ? trig_r_q : trig_f_q);

  always_comb begin
    tag.first = (iss_k == 2'd0);
    tag.last  = (iss_k == 2'd3);
    tag.idx   = {mat_sel, iss_i, iss_j};
  end

  rma_mac #(
    .FRAC_BITS(FRAC_BITS)
  ) u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .issue_i  (issue),
    .a_i      (mac_a),
    .b_i      (mac_b),
    .tag_i    (tag),
    .busy_o   (mac_busy),
    .wr_en_o  (wr_en),
    .wr_idx_o (wr_idx),
    .wr_data_o(wr_data)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && command_i != AxisNone) begin
          state_d = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (!sh_q) begin
          state_d = ST_TRIG_F;
        end
      end
      ST_TRIG_F: state_d = ST_TRIG_R;
      ST_TRIG_R: state_d = ST_MAC;
      ST_MAC: begin
        if (iss_q == 7'd127) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!mac_busy) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (load_out && em_q == 5'd31) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      out_vld_q <= 1'b0;
      iss_q     <= '0;
      em_q      <= '0;
      sh_q      <= 1'b0;
      for (int n = 0; n < Cells * 2; n++) begin
        mem_q[n] <= (n[1:0] == n[3:2]) ? OneElem : '0;
      end
    end else begin
      state_q <= state_d;
      if (accept) begin
        sh_q  <= 1'b1;
        iss_q <= '0;
        em_q  <= '0;
      end
      if (state_q == ST_REDUCE && sh_q) begin
        sh_q <= 1'b0;
      end
      if (issue) begin
        iss_q <= iss_q + 7'd1;
      end
      if (wr_en) begin
        mem_q[wr_idx] <= wr_data;
      end
      if (load_out) begin
        out_vld_q <= 1'b1;
        em_q      <= em_q + 5'd1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      axis_q <= command_i;
      neg_q  <= angle_degrees_i[15];
      red_q  <= angle_degrees_i[15] ? 17'd0 - 17'(angle_degrees_i) : 17'(angle_degrees_i);
    end
    if (state_q == ST_REDUCE) begin
      if (sh_q) begin
        quo_q <= 7'(quo_prod >> 23);
      end else begin
        red_q <= red_q - 17'(quo_q) * 17'd360;
      end
    end
    if (state_q == ST_TRIG_F) begin
      trig_f_q <= trig_w;
      rev_q    <= rev_ang;
    end
    if (state_q == ST_TRIG_R) begin
      trig_r_q <= trig_w;
    end
    if (issue && iss_j == 2'd0) begin
      row_q[iss_k] <= rd_data;
    end
    if (load_out) begin
      out_sel_q  <= em_q[4];
      out_row_q  <= em_q[3:2];
      out_col_q  <= em_q[1:0];
      out_val_q  <= rd_data;
      out_last_q <= (em_q == 5'd31);
    end
  end

  assign out_valid_o     = out_vld_q;
  assign matrix_select_o = out_sel_q;
  assign row_o           = out_row_q;
  assign col_o           = out_col_q;
  assign element_value_o = out_val_q;
  assign last_o          = out_last_q;

endmodule

`default_nettype wire
